// File: rtl/pot_pkg.sv
package pot_pkg;

    localparam int unsigned CoordWidth  = 32;
    localparam int unsigned SizeWidth   = 31;
    localparam int unsigned OrientWidth = 4;
    localparam int unsigned ModeWidth   = 2;
    localparam int unsigned CfgIdxWidth = 3;

    // Orientation codes.
    localparam logic [OrientWidth-1:0] ORIENT_NONE = 4'd0;
    localparam logic [OrientWidth-1:0] ORIENT_R0   = 4'd1;
    localparam logic [OrientWidth-1:0] ORIENT_R180 = 4'd2;
    localparam logic [OrientWidth-1:0] ORIENT_R90  = 4'd3;
    localparam logic [OrientWidth-1:0] ORIENT_R270 = 4'd4;
    localparam logic [OrientWidth-1:0] ORIENT_MY   = 4'd5;
    localparam logic [OrientWidth-1:0] ORIENT_MX   = 4'd6;
    localparam logic [OrientWidth-1:0] ORIENT_MX90 = 4'd7;
    localparam logic [OrientWidth-1:0] ORIENT_MY90 = 4'd8;

    // Request modes.
    localparam logic [ModeWidth-1:0] MODE_FWD_POINT = 2'd0;
    localparam logic [ModeWidth-1:0] MODE_INV_POINT = 2'd1;
    localparam logic [ModeWidth-1:0] MODE_FWD_RECT  = 2'd2;

    // Configuration register indexes.
    localparam logic [CfgIdxWidth-1:0] CFG_ORIENT   = 3'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_ORIGIN_X = 3'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_ORIGIN_Y = 3'd2;
    localparam logic [CfgIdxWidth-1:0] CFG_WIDTH    = 3'd3;
    localparam logic [CfgIdxWidth-1:0] CFG_HEIGHT   = 3'd4;

    typedef struct packed {
        logic [OrientWidth-1:0] orient;
        logic [CoordWidth-1:0]  origin_x;
        logic [CoordWidth-1:0]  origin_y;
        logic [SizeWidth-1:0]   width;
        logic [SizeWidth-1:0]   height;
    } t_pot_cfg;

endpackage

// File: rtl/pot_cfg.sv
module pot_cfg
    import pot_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic [CfgIdxWidth-1:0] i_cfg_index,
    input  logic [CoordWidth-1:0]  i_cfg_data,
    output t_pot_cfg               o_cfg
);

    t_pot_cfg r_cfg;
    t_pot_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ORIENT:   n_cfg.orient   = i_cfg_data[OrientWidth-1:0];
                CFG_ORIGIN_X: n_cfg.origin_x = i_cfg_data;
                CFG_ORIGIN_Y: n_cfg.origin_y = i_cfg_data;
                CFG_WIDTH:    n_cfg.width    = i_cfg_data[SizeWidth-1:0];
                CFG_HEIGHT:   n_cfg.height   = i_cfg_data[SizeWidth-1:0];
                default:      n_cfg          = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/pot_map.sv
module pot_map
    import pot_pkg::*;
(
    input  t_pot_cfg              i_cfg,
    input  logic                  i_inverse,
    input  logic [CoordWidth-1:0] i_x,
    input  logic [CoordWidth-1:0] i_y,
    output logic [CoordWidth-1:0] o_x,
    output logic [CoordWidth-1:0] o_y
);

    logic [CoordWidth-1:0] dx, dy, ndx, ndy, w, h, ox, oy;

    assign ox  = i_cfg.origin_x;
    assign oy  = i_cfg.origin_y;
    assign w   = {1'b0, i_cfg.width};
    assign h   = {1'b0, i_cfg.height};
    assign dx  = i_x - ox;
    assign dy  = i_y - oy;
    assign ndx = '0 - dx;
    assign ndy = '0 - dy;

    always_comb begin
        o_x = i_x;
        o_y = i_y;
        if (i_inverse) begin
            case (i_cfg.orient)
                ORIENT_R0:   begin o_x = dx;     o_y = dy;     end
                ORIENT_R180: begin o_x = w - dx; o_y = h - dy; end
                ORIENT_R90:  begin o_x = dy;     o_y = h - dx; end
                ORIENT_R270: begin o_x = w - dy; o_y = dx;     end
                ORIENT_MY:   begin o_x = w - dx; o_y = dy;     end
                ORIENT_MX:   begin o_x = dx;     o_y = h - dy; end
                ORIENT_MX90: begin o_x = dy;     o_y = dx;     end
                ORIENT_MY90: begin o_x = w - dy; o_y = h - dx; end
                default:     begin o_x = i_x;    o_y = i_y;    end
            endcase
        end else begin
            // Forward R0 leaves the point as it is, like the unplaced code.
            case (i_cfg.orient)
                ORIENT_R180: begin o_x = ndx + w + ox; o_y = ndy + h + oy; end
                ORIENT_R90:  begin o_x = ndy + h + ox; o_y = dx + oy;      end
                ORIENT_R270: begin o_x = dy + ox;      o_y = ndx + w + oy; end
                ORIENT_MY:   begin o_x = ndx + w + ox; o_y = dy + oy;      end
                ORIENT_MX:   begin o_x = dx + ox;      o_y = ndy + h + oy; end
                ORIENT_MX90: begin o_x = dy + ox;      o_y = dx + oy;      end
                ORIENT_MY90: begin o_x = ndy + h + ox; o_y = ndx + w + oy; end
                default:     begin o_x = i_x;          o_y = i_y;          end
            endcase
        end
    end

endmodule

// File: rtl/placement_orientation_transform.sv
// Placement orientation transform. Each request carries a mode and up to two
// points; the block maps them by the configured orientation, origin and cell
// size and returns one result per request. Mode 0 maps a point forward into
// placed coordinates, mode 1 maps a point back to cell-master coordinates,
// and mode 2 maps both corners of a rectangle forward and returns its signed
// minimum and maximum corners; in point modes the second result corner is
// zero, and mode 3 returns all zeros. Arithmetic wraps at 32 bits. The block
// takes one request every clock cycle while its results are taken: a request
// is captured in an input register, mapped by two point-mapping units and the
// rectangle min/max compare in the next cycle, and held in an output
// register, from which the result is offered until it is taken. Both channels
// use valid/ready; a stalled result holds the pipeline, and the input register
// still takes a request while the output register is being emptied.
// Configuration writes are taken in every cycle and must only be issued while
// no request is in flight.
module placement_orientation_transform
    import pot_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CfgIdxWidth-1:0] i_cfg_index,
    input  logic [CoordWidth-1:0]  i_cfg_data,

    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [ModeWidth-1:0]   i_mode,
    input  logic [CoordWidth-1:0]  i_in_x0,
    input  logic [CoordWidth-1:0]  i_in_y0,
    input  logic [CoordWidth-1:0]  i_in_x1,
    input  logic [CoordWidth-1:0]  i_in_y1,

    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [CoordWidth-1:0]  o_out_x0,
    output logic [CoordWidth-1:0]  o_out_y0,
    output logic [CoordWidth-1:0]  o_out_x1,
    output logic [CoordWidth-1:0]  o_out_y1
);

    t_pot_cfg cfg;

    // Input stage.
    logic                  r_in_valid;
    logic [ModeWidth-1:0]  r_mode;
    logic [CoordWidth-1:0] r_x0, r_y0, r_x1, r_y1;

    // Output stage; r_out_rect marks a rectangle result.
    logic                  r_out_valid;
    logic                  r_out_rect;
    logic [CoordWidth-1:0] r_out_x0, r_out_y0, r_out_x1, r_out_y1;
    logic [CoordWidth-1:0] n_out_x0, n_out_y0, n_out_x1, n_out_y1;

    logic                  advance;
    logic                  in_accept;
    logic [CoordWidth-1:0] ax, ay, bx, by;

    // The configuration registers never stall a write.
    assign o_cfg_ready = 1'b1;

    pot_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // The first unit serves points of both directions and the first corner of
    // a rectangle; the second unit maps the second corner only.
    pot_map u_map_a (
        .i_cfg     (cfg),
        .i_inverse (r_mode == MODE_INV_POINT),
        .i_x       (r_x0),
        .i_y       (r_y0),
        .o_x       (ax),
        .o_y       (ay)
    );

    pot_map u_map_b (
        .i_cfg     (cfg),
        .i_inverse (1'b0),
        .i_x       (r_x1),
        .i_y       (r_y1),
        .o_x       (bx),
        .o_y       (by)
    );

    // The output register loads whenever it is empty or being drained.
    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || advance;
    assign in_accept  = i_in_valid && o_in_ready;

    always_comb begin
        n_out_x0 = '0;
        n_out_y0 = '0;
        n_out_x1 = '0;
        n_out_y1 = '0;
        case (r_mode)
            MODE_FWD_POINT, MODE_INV_POINT: begin
                n_out_x0 = ax;
                n_out_y0 = ay;
            end
            MODE_FWD_RECT: begin
                n_out_x0 = ($signed(bx) < $signed(ax)) ? bx : ax;
                n_out_y0 = ($signed(by) < $signed(ay)) ? by : ay;
                n_out_x1 = ($signed(ax) < $signed(bx)) ? bx : ax;
                n_out_y1 = ($signed(ay) < $signed(by)) ? by : ay;
            end
            default: begin
                n_out_x0 = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_mode <= i_mode;
            r_x0   <= i_in_x0;
            r_y0   <= i_in_y0;
            r_x1   <= i_in_x1;
            r_y1   <= i_in_y1;
        end
        if (advance) begin
            r_out_rect <= (r_mode == MODE_FWD_RECT);
            r_out_x0   <= n_out_x0;
            r_out_y0   <= n_out_y0;
            r_out_x1   <= n_out_x1;
            r_out_y1   <= n_out_y1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_x0    = r_out_x0;
    assign o_out_y0    = r_out_y0;
    assign o_out_x1    = r_out_x1;
    assign o_out_y1    = r_out_y1;

    // A held request in the input stage is not overwritten while stalled.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_x0) && $stable(r_mode)))
        else $error("input stage lost a stalled request");

    // A request in the input stage moves to the output stage when it advances.
    a_forward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && advance) |=> r_out_valid)
        else $error("request dropped between stages");

    // Rectangle results are ordered corners.
    a_rect_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_rect) |->
            ($signed(r_out_x0) <= $signed(r_out_x1) &&
             $signed(r_out_y0) <= $signed(r_out_y1)))
        else $error("rectangle corners out of order");

    // Point results leave the second corner at zero.
    a_point_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_rect) |-> (r_out_x1 == '0 && r_out_y1 == '0))
        else $error("point result with nonzero second corner");

endmodule
